// ----- src/iss_pkg.sv -----
package iss_pkg;

   localparam int CAPACITY_DEF = 1024;

   // fixed field widths of the transaction payloads
   localparam int CMD_W       = 4;
   localparam int POS_W       = 10;
   localparam int WORD_W      = 32;
   localparam int STATUS_W    = 2;
   localparam int FIDX_W      = 10;
   localparam int COUNT_OUT_W = 11;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 56;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 4'd0,
      CMD_PUSH_BACK  = 4'd1,
      CMD_POP_FRONT  = 4'd2,
      CMD_POP_BACK   = 4'd3,
      CMD_INSERT     = 4'd4,
      CMD_REMOVE     = 4'd5,
      CMD_REPLACE    = 4'd6,
      CMD_READ       = 4'd7,
      CMD_FIND       = 4'd8,
      CMD_SIZE       = 4'd9
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_RANGE    = 2'd1,
      STAT_FULL     = 2'd2,
      STAT_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_SHIFT_UP,
      S_SHIFT_DN,
      S_FLUSH_UP,
      S_FLUSH_DN,
      S_PLACE,
      S_RD_WAIT,
      S_FIND,
      S_RESP
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,
      OP_APPEND,
      OP_PUT,
      OP_PLACE,
      OP_DROP,
      OP_SHUP_INIT,
      OP_SHDN_INIT,
      OP_STEP_UP,
      OP_STEP_DN,
      OP_READ,
      OP_CAPTURE,
      OP_FIND_INIT,
      OP_FIND_STEP,
      OP_RESPOND
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic       set_status;
      status_type status;
   } ctrl_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    pos_oor;
      logic    full;
      logic    empty;
      logic    no_shift_up;
      logic    no_shift_dn;
      logic    up_last;
      logic    dn_last;
      logic    find_hit;
      logic    find_miss;
      logic    out_free;
   } dp_stat_type;

endpackage

// ----- src/indexed_sequence_store.sv -----
// each request is latched in idle and decoded; push back, pop back, replace, size and errors then
//   go straight to the response, a read waits for the registered memory read, moves shift entries
//   one by one and then flush, a placed word is written last, and a find compares from both ends
// one transaction at a time, a new request is taken only in idle; the worst case is a find with no
//   match on a full store, set by the single read and write ports of the memory
// reset: synchronous, active high; empties the store (count zero) and drops any pending response
module indexed_sequence_store #(
   parameter int CAPACITY = iss_pkg::CAPACITY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [iss_pkg::REQ_DATA_W-1:0]    req_tdata,  // position[9:0], data_word[41:10]
   input  logic [iss_pkg::CMD_W-1:0]         req_tuser,  // command[3:0]
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [iss_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // read_word[31:0], found_index[41:32],
                                                         // entry_count[52:42]
   output logic [iss_pkg::STATUS_W-1:0]      rsp_tuser   // status[1:0]
);
   import iss_pkg::*;

   ctrl_cmd_type ctrl_cmd;   // controller to datapath operation
   dp_stat_type  dp_stat;    // datapath conditions seen by the controller

   logic signed [WORD_W-1:0] read_word;
   logic [FIDX_W-1:0]        found_index;
   logic [COUNT_OUT_W-1:0]   entry_count;

   // sequencer: decode, shift walk, find walk, response hand-off
   iss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (dp_stat),
      .cmd        (ctrl_cmd)
   );

   // entry memory, count, pointers and the response register
   iss_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (ctrl_cmd),
      .stat            (dp_stat),
      .req_cmd         (req_tuser),
      .req_pos         (req_tdata[POS_W-1:0]),
      .req_word        (req_tdata[POS_W+WORD_W-1:POS_W]),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_status      (rsp_tuser),
      .rsp_read_word   (read_word),
      .rsp_found_index (found_index),
      .rsp_entry_count (entry_count)
   );

   // pack the response fields, low field first, zero padded to whole bytes
   assign rsp_tdata = {{(RSP_DATA_W-WORD_W-FIDX_W-COUNT_OUT_W){1'b0}},
                       entry_count, found_index, read_word};

endmodule

// ----- src/iss_ctrl.sv -----
module iss_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  iss_pkg::dp_stat_type stat,
   output iss_pkg::ctrl_cmd_type cmd
);
   import iss_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_DECODE;
         end
         S_DECODE: begin
            state_in = S_RESP;
            case (stat.cmd)
               CMD_PUSH_FRONT: begin
                  if (!stat.full) state_in = stat.no_shift_up ? S_PLACE : S_SHIFT_UP;
               end
               CMD_INSERT: begin
                  if (!stat.pos_oor && !stat.full) begin
                     state_in = stat.no_shift_up ? S_PLACE : S_SHIFT_UP;
                  end
               end
               CMD_POP_FRONT: begin
                  if (!stat.empty && !stat.no_shift_dn) state_in = S_SHIFT_DN;
               end
               CMD_REMOVE: begin
                  if (!stat.pos_oor && !stat.no_shift_dn) state_in = S_SHIFT_DN;
               end
               CMD_READ: begin
                  if (!stat.pos_oor) state_in = S_RD_WAIT;
               end
               CMD_FIND: begin
                  if (!stat.empty) state_in = S_FIND;
               end
               default: state_in = S_RESP;
            endcase
         end
         S_SHIFT_UP: begin
            if (stat.up_last) state_in = S_FLUSH_UP;
         end
         S_SHIFT_DN: begin
            if (stat.dn_last) state_in = S_FLUSH_DN;
         end
         S_FLUSH_UP: state_in = S_PLACE;
         S_FLUSH_DN: state_in = S_RESP;
         S_PLACE:    state_in = S_RESP;
         S_RD_WAIT:  state_in = S_RESP;
         S_FIND: begin
            if (stat.find_hit || stat.find_miss) state_in = S_RESP;
         end
         S_RESP: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready     = (state_ff == S_IDLE);
      cmd.op         = OP_NONE;
      cmd.set_status = 1'b0;
      cmd.status     = STAT_OK;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) cmd.op = OP_LATCH;
         end
         S_DECODE: begin
            case (stat.cmd)
               CMD_PUSH_FRONT: begin
                  if (stat.full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = STAT_FULL;
                  end else if (!stat.no_shift_up) begin
                     cmd.op = OP_SHUP_INIT;
                  end
               end
               CMD_PUSH_BACK: begin
                  if (stat.full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = STAT_FULL;
                  end else begin
                     cmd.op = OP_APPEND;
                  end
               end
               CMD_POP_FRONT: begin
                  if (!stat.empty) cmd.op = stat.no_shift_dn ? OP_DROP : OP_SHDN_INIT;
               end
               CMD_POP_BACK: begin
                  if (!stat.empty) cmd.op = OP_DROP;
               end
               CMD_INSERT: begin
                  if (stat.pos_oor) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = STAT_RANGE;
                  end else if (stat.full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = STAT_FULL;
                  end else if (!stat.no_shift_up) begin
                     cmd.op = OP_SHUP_INIT;
                  end
               end
               CMD_REMOVE: begin
                  if (stat.pos_oor) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = STAT_RANGE;
                  end else begin
                     cmd.op = stat.no_shift_dn ? OP_DROP : OP_SHDN_INIT;
                  end
               end
               CMD_REPLACE: begin
                  if (stat.pos_oor) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = STAT_RANGE;
                  end else begin
                     cmd.op = OP_PUT;
                  end
               end
               CMD_READ: begin
                  if (stat.pos_oor) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = STAT_RANGE;
                  end else begin
                     cmd.op = OP_READ;
                  end
               end
               CMD_FIND: begin
                  cmd.set_status = 1'b1;
                  cmd.status     = STAT_NOTFOUND;
                  if (!stat.empty) cmd.op = OP_FIND_INIT;
               end
               default: cmd.op = OP_NONE;
            endcase
         end
         S_SHIFT_UP: cmd.op = OP_STEP_UP;
         S_SHIFT_DN: cmd.op = OP_STEP_DN;
         S_FLUSH_UP: cmd.op = OP_NONE;
         S_FLUSH_DN: cmd.op = OP_DROP;
         S_PLACE:    cmd.op = OP_PLACE;
         S_RD_WAIT:  cmd.op = OP_CAPTURE;
         S_FIND: begin
            cmd.op = OP_FIND_STEP;
            if (stat.find_hit) begin
               cmd.set_status = 1'b1;
               cmd.status     = STAT_OK;
            end
         end
         S_RESP: begin
            if (stat.out_free) cmd.op = OP_RESPOND;
         end
         default: cmd.op = OP_NONE;
      endcase
   end

endmodule

// ----- src/iss_dpath.sv -----
module iss_dpath #(
   parameter int CAPACITY = iss_pkg::CAPACITY_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  iss_pkg::ctrl_cmd_type                cmd,
   output iss_pkg::dp_stat_type                 stat,
   input  logic [iss_pkg::CMD_W-1:0]            req_cmd,
   input  logic [iss_pkg::POS_W-1:0]            req_pos,
   input  logic signed [iss_pkg::WORD_W-1:0]    req_word,
   input  logic                                 rsp_tready,
   output logic                                 rsp_tvalid,
   output logic [iss_pkg::STATUS_W-1:0]         rsp_status,
   output logic signed [iss_pkg::WORD_W-1:0]    rsp_read_word,
   output logic [iss_pkg::FIDX_W-1:0]           rsp_found_index,
   output logic [iss_pkg::COUNT_OUT_W-1:0]      rsp_entry_count
);
   import iss_pkg::*;

   localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   // entry storage, one write and one registered read per cycle
   logic [WORD_W-1:0] store_mem [CAPACITY];
   logic [WORD_W-1:0] rdata_ff;
   logic              mem_we;
   logic [IW-1:0]     mem_waddr;
   logic [IW-1:0]     mem_raddr;
   logic [WORD_W-1:0] mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) store_mem[mem_waddr] <= mem_wdata;
      rdata_ff <= store_mem[mem_raddr];
   end

   cmd_type           cmd_ff, cmd_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [CW-1:0]     count_ff, count_in;
   status_type        status_ff, status_in;
   logic [WORD_W-1:0] rd_ff, rd_in;
   logic [IW-1:0]     fidx_ff, fidx_in;
   logic [IW-1:0]     ptr_ff, ptr_in;
   logic              pend_ff, pend_in;
   logic [IW-1:0]     pend_addr_ff, pend_addr_in;
   logic [IW-1:0]     fi_ff, fi_in;
   logic [IW-1:0]     fj_ff, fj_in;
   logic              side_ff, side_in;
   logic              issue_done_ff, issue_done_in;
   logic              cmp_valid_ff, cmp_valid_in;
   logic              cmp_last_ff, cmp_last_in;
   logic [IW-1:0]     cmp_addr_ff, cmp_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [WORD_W-1:0] rsp_read_ff, rsp_read_in;
   logic [FIDX_W-1:0] rsp_fidx_ff, rsp_fidx_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;

   logic          front_cmd;
   logic [IW-1:0] at_idx;
   logic [IW-1:0] find_addr;
   logic [CW-1:0] half_count;
   logic          hit;

   assign front_cmd  = (cmd_ff == CMD_PUSH_FRONT) || (cmd_ff == CMD_POP_FRONT);
   assign at_idx     = front_cmd ? '0 : IW'(pos_ff);
   assign find_addr  = side_ff ? fj_ff : fi_ff;
   assign half_count = count_ff >> 1;
   assign hit        = cmp_valid_ff && (rdata_ff == word_ff);

   always_comb begin
      stat.cmd         = cmd_ff;
      stat.pos_oor     = CMPW'(pos_ff) >= CMPW'(count_ff);
      stat.full        = count_ff == CW'(CAPACITY);
      stat.empty       = count_ff == '0;
      stat.no_shift_up = count_ff == CW'(at_idx);
      stat.no_shift_dn = (CW'(at_idx) + CW'(1)) == count_ff;
      stat.up_last     = ptr_ff == at_idx;
      stat.dn_last     = CW'(ptr_ff) == (count_ff - CW'(1));
      stat.find_hit    = hit;
      stat.find_miss   = cmp_valid_ff && cmp_last_ff && !hit;
      stat.out_free    = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      cmd_in        = cmd_ff;
      pos_in        = pos_ff;
      word_in       = word_ff;
      count_in      = count_ff;
      status_in     = status_ff;
      rd_in         = rd_ff;
      fidx_in       = fidx_ff;
      ptr_in        = ptr_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      fi_in         = fi_ff;
      fj_in         = fj_ff;
      side_in       = side_ff;
      issue_done_in = issue_done_ff;
      cmp_valid_in  = 1'b0;
      cmp_last_in   = cmp_last_ff;
      cmp_addr_in   = cmp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_read_in   = rsp_read_ff;
      rsp_fidx_in   = rsp_fidx_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      mem_raddr = ptr_ff;
      mem_we    = 1'b0;
      mem_waddr = at_idx;
      mem_wdata = word_ff;
      // moved entry from the previous shift step
      if (pend_ff) begin
         mem_we    = 1'b1;
         mem_waddr = pend_addr_ff;
         mem_wdata = rdata_ff;
      end

      if (cmd.set_status) status_in = cmd.status;

      case (cmd.op)
         OP_LATCH: begin
            cmd_in    = cmd_type'(req_cmd);
            pos_in    = req_pos;
            word_in   = req_word;
            status_in = STAT_OK;
            rd_in     = '0;
            fidx_in   = '0;
         end
         OP_APPEND: begin
            mem_we    = 1'b1;
            mem_waddr = IW'(count_ff);
            count_in  = count_ff + CW'(1);
         end
         OP_PUT: begin
            mem_we = 1'b1;
         end
         OP_PLACE: begin
            mem_we   = 1'b1;
            count_in = count_ff + CW'(1);
         end
         OP_DROP: begin
            count_in = count_ff - CW'(1);
         end
         OP_SHUP_INIT: begin
            ptr_in = IW'(count_ff - CW'(1));
         end
         OP_SHDN_INIT: begin
            ptr_in = at_idx + IW'(1);
         end
         OP_STEP_UP: begin
            mem_raddr    = ptr_ff;
            pend_in      = 1'b1;
            pend_addr_in = ptr_ff + IW'(1);
            ptr_in       = ptr_ff - IW'(1);
         end
         OP_STEP_DN: begin
            mem_raddr    = ptr_ff;
            pend_in      = 1'b1;
            pend_addr_in = ptr_ff - IW'(1);
            ptr_in       = ptr_ff + IW'(1);
         end
         OP_READ: begin
            mem_raddr = at_idx;
         end
         OP_CAPTURE: begin
            rd_in = rdata_ff;
         end
         OP_FIND_INIT: begin
            fi_in         = '0;
            fj_in         = IW'(count_ff - CW'(1));
            side_in       = 1'b0;
            issue_done_in = 1'b0;
         end
         OP_FIND_STEP: begin
            // front and back reads alternate, each compared in the cycle after its read
            if (!issue_done_ff) begin
               mem_raddr    = find_addr;
               cmp_valid_in = 1'b1;
               cmp_addr_in  = find_addr;
               cmp_last_in  = side_ff && (CW'(fi_ff) == half_count);
               if (side_ff) begin
                  fi_in         = fi_ff + IW'(1);
                  fj_in         = fj_ff - IW'(1);
                  side_in       = 1'b0;
                  issue_done_in = side_ff && (CW'(fi_ff) == half_count);
               end else begin
                  side_in = 1'b1;
               end
            end
            if (hit) fidx_in = cmp_addr_ff;
         end
         OP_RESPOND: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = status_ff;
            rsp_read_in   = rd_ff;
            rsp_fidx_in   = FIDX_W'(fidx_ff);
            rsp_count_in  = COUNT_OUT_W'(count_ff);
         end
         default: begin
            mem_raddr = ptr_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         pend_ff       <= 1'b0;
         cmp_valid_ff  <= 1'b0;
         issue_done_ff <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         pend_ff       <= pend_in;
         cmp_valid_ff  <= cmp_valid_in;
         issue_done_ff <= issue_done_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      pos_ff        <= pos_in;
      word_ff       <= word_in;
      status_ff     <= status_in;
      rd_ff         <= rd_in;
      fidx_ff       <= fidx_in;
      ptr_ff        <= ptr_in;
      pend_addr_ff  <= pend_addr_in;
      fi_ff         <= fi_in;
      fj_ff         <= fj_in;
      side_ff       <= side_in;
      cmp_last_ff   <= cmp_last_in;
      cmp_addr_ff   <= cmp_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_fidx_ff   <= rsp_fidx_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_word   = rsp_read_ff;
   assign rsp_found_index = rsp_fidx_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule
